// ----- hw/rtl/thda_pkg.sv -----
// Shared types and constants for the thumb data-processing execute block.
// Holds the operation codes, flag and result structs and operand-select decode.
// No dependencies.
`timescale 1ns / 1ps

package thda_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned REG_CNT = 16;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned OP_W    = 6;
  localparam int unsigned FA_W    = 8;
  localparam int unsigned FB_W    = 4;
  localparam int unsigned FC_W    = 5;

  localparam logic [IDX_W-1:0]  SP_IDX         = 4'd13;
  localparam logic [IDX_W-1:0]  PC_IDX         = 4'd15;
  localparam logic [DATA_W-1:0] PC_ALIGN_MASK  = 32'hFFFF_FFFC;

  // instruction kinds
  typedef enum logic [OP_W-1:0] {
    OP_ADD_REG     = 6'd0,
    OP_SUB_REG     = 6'd1,
    OP_ADD_IMM     = 6'd2,
    OP_SUB_IMM     = 6'd3,
    OP_ADD_LAR_IMM = 6'd4,
    OP_SUB_LAR_IMM = 6'd5,
    OP_MOV_IMM     = 6'd6,
    OP_CMP_IMM     = 6'd7,
    OP_LSL_IMM     = 6'd8,
    OP_LSR_IMM     = 6'd9,
    OP_ASR_IMM     = 6'd10,
    OP_AND         = 6'd11,
    OP_EOR         = 6'd12,
    OP_ORR         = 6'd13,
    OP_BIC         = 6'd14,
    OP_ADC         = 6'd15,
    OP_SBC         = 6'd16,
    OP_MVN         = 6'd17,
    OP_MUL         = 6'd18,
    OP_NEG         = 6'd19,
    OP_TST         = 6'd20,
    OP_CMP_REG     = 6'd21,
    OP_CMN         = 6'd22,
    OP_LSL_REG     = 6'd23,
    OP_LSR_REG     = 6'd24,
    OP_ASR_REG     = 6'd25,
    OP_ROR         = 6'd26,
    OP_ADD_IMM_PC  = 6'd27,
    OP_ADD_IMM_SP  = 6'd28,
    OP_ADD_INC_SP  = 6'd29,
    OP_SUB_DEC_SP  = 6'd30,
    OP_ADD_HIG_REG = 6'd31,
    OP_CMP_HIG_REG = 6'd32,
    OP_MOV_HIG_REG = 6'd33
  } op_t;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic [IDX_W-1:0]  dest_index;
    logic              dest_written;
    flags_t            flags;
  } exec_res_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } rf_wr_t;

  // address of the second register read: Rm, PC, SP or Rd
  function automatic logic [IDX_W-1:0] opnd_sel(input op_t op,
                                                input logic [FA_W-1:0] fa,
                                                input logic [FC_W-1:0] fc);
    logic [IDX_W-1:0] sel;
    sel = fa[IDX_W-1:0];
    case (op)
      OP_ADD_REG, OP_SUB_REG: sel = fc[IDX_W-1:0];
      OP_ADD_IMM_PC:          sel = PC_IDX;
      OP_ADD_IMM_SP, OP_ADD_INC_SP, OP_SUB_DEC_SP: sel = SP_IDX;
      default:                sel = fa[IDX_W-1:0];
    endcase
    return sel;
  endfunction

endpackage

// ----- hw/rtl/thda_regfile.sv -----
// 16 x 32-bit register file with two registered read ports and one write port.
// A write in the same cycle as a read of the same entry is forwarded. Uses thda_pkg.
`timescale 1ns / 1ps

module thda_regfile (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [thda_pkg::IDX_W-1:0] rd_addr_a,
  input  logic [thda_pkg::IDX_W-1:0] rd_addr_b,
  input  thda_pkg::rf_wr_t           wr,
  output logic [thda_pkg::DATA_W-1:0] rd_data_a,
  output logic [thda_pkg::DATA_W-1:0] rd_data_b
);
  import thda_pkg::*;

  logic [DATA_W-1:0] mem_r [REG_CNT];
  logic [DATA_W-1:0] rd_a_r, rd_b_r;
  logic [DATA_W-1:0] rd_a_nxt, rd_b_nxt;

  // read with forwarding of the write in flight
  always_comb begin
    rd_a_nxt = (wr.en && (wr.addr == rd_addr_a)) ? wr.data : mem_r[rd_addr_a];
    rd_b_nxt = (wr.en && (wr.addr == rd_addr_b)) ? wr.data : mem_r[rd_addr_b];
  end

  // storage, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_CNT; i++) begin
        mem_r[i] <= '0;
      end
    end else if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  // registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= rd_a_nxt;
      rd_b_r <= rd_b_nxt;
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// ----- hw/rtl/thda_exec.sv -----
// Combinational execute unit: flag adder, barrel shifter, logic, multiply, address adds.
// Produces result value, destination and flags for one item. Uses thda_pkg.
`timescale 1ns / 1ps

module thda_exec (
  input  thda_pkg::op_t               op,
  input  logic [thda_pkg::FA_W-1:0]   fa,
  input  logic [thda_pkg::FB_W-1:0]   fb,
  input  logic [thda_pkg::FC_W-1:0]   fc,
  input  logic [thda_pkg::DATA_W-1:0] opnd_m,
  input  logic [thda_pkg::DATA_W-1:0] opnd_x,
  input  thda_pkg::flags_t            flags_in,
  output thda_pkg::exec_res_t         res
);
  import thda_pkg::*;

  typedef enum logic [1:0] {SH_LSL, SH_LSR, SH_ASR, SH_ROR} sh_kind_t;

  logic [DATA_W-1:0]   add_a, add_b;
  logic                add_cin;
  logic [DATA_W:0]     add_sum;
  logic                add_v;
  logic [DATA_W-1:0]   sh_val;
  logic [7:0]          sh_amt;
  sh_kind_t            sh_kind;
  logic [4:0]          sh5;
  logic [2*DATA_W-1:0] lsl_w, lsr_w, ror_w;
  logic signed [2*DATA_W-1:0] asr_w;
  logic [DATA_W-1:0]   sh_r;
  logic                sh_c;
  logic [2*DATA_W-1:0] mul_w;
  logic [DATA_W-1:0]   imm_x4;
  logic [DATA_W-1:0]   pl_a, pl_b, pl_sum;
  logic                pl_sub;
  logic [DATA_W-1:0]   r;
  logic                nz;

  // operand selection for the flag adder and shifter
  always_comb begin
    add_a   = opnd_x;
    add_b   = opnd_m;
    add_cin = 1'b0;
    sh_val  = opnd_x;
    sh_amt  = opnd_m[7:0];
    sh_kind = SH_LSL;
    case (op)
      OP_ADD_REG: begin
        add_a = opnd_m; add_b = opnd_x;
      end
      OP_SUB_REG: begin
        add_a = opnd_m; add_b = ~opnd_x; add_cin = 1'b1;
      end
      OP_ADD_IMM: begin
        add_a = opnd_m; add_b = {27'd0, fc};
      end
      OP_SUB_IMM: begin
        add_a = opnd_m; add_b = ~{27'd0, fc}; add_cin = 1'b1;
      end
      OP_ADD_LAR_IMM: begin
        add_a = opnd_m; add_b = {24'd0, fa};
      end
      OP_SUB_LAR_IMM, OP_CMP_IMM: begin
        add_a = opnd_m; add_b = ~{24'd0, fa}; add_cin = 1'b1;
      end
      OP_ADC: begin
        add_cin = flags_in.c;
      end
      OP_SBC: begin
        add_b = ~opnd_m; add_cin = flags_in.c;
      end
      OP_NEG: begin
        add_a = '0; add_b = ~opnd_m; add_cin = 1'b1;
      end
      OP_CMP_REG, OP_CMP_HIG_REG: begin
        add_b = ~opnd_m; add_cin = 1'b1;
      end
      OP_LSL_IMM: begin
        sh_val = opnd_m; sh_amt = {3'd0, fc};
      end
      // immediate right shifts by zero encode a shift by 32
      OP_LSR_IMM: begin
        sh_val  = opnd_m; sh_kind = SH_LSR;
        sh_amt  = (fc == '0) ? 8'd32 : {3'd0, fc};
      end
      OP_ASR_IMM: begin
        sh_val  = opnd_m; sh_kind = SH_ASR;
        sh_amt  = (fc == '0) ? 8'd32 : {3'd0, fc};
      end
      OP_LSR_REG: sh_kind = SH_LSR;
      OP_ASR_REG: sh_kind = SH_ASR;
      OP_ROR:     sh_kind = SH_ROR;
      default: ;
    endcase
  end

  // flag adder
  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{DATA_W{1'b0}}, add_cin};
  assign add_v   = (add_a[DATA_W-1] ^ add_sum[DATA_W-1])
                 & (add_b[DATA_W-1] ^ add_sum[DATA_W-1]);

  // barrel shifter on a double-width word so the last bit out is the carry
  assign sh5   = sh_amt[4:0];
  assign lsl_w = {{DATA_W{1'b0}}, sh_val} << sh5;
  assign lsr_w = {sh_val, {DATA_W{1'b0}}} >> sh5;
  assign asr_w = $signed({sh_val, {DATA_W{1'b0}}}) >>> sh5;
  assign ror_w = {sh_val, sh_val} >> sh5;

  always_comb begin
    sh_r = sh_val;
    sh_c = flags_in.c;
    if (sh_amt != '0) begin
      case (sh_kind)
        SH_LSL: begin
          if (sh_amt[7:5] == '0) begin
            sh_r = lsl_w[DATA_W-1:0]; sh_c = lsl_w[DATA_W];
          end else if (sh_amt == 8'd32) begin
            sh_r = '0; sh_c = sh_val[0];
          end else begin
            sh_r = '0; sh_c = 1'b0;
          end
        end
        SH_LSR: begin
          if (sh_amt[7:5] == '0) begin
            sh_r = lsr_w[2*DATA_W-1:DATA_W]; sh_c = lsr_w[DATA_W-1];
          end else if (sh_amt == 8'd32) begin
            sh_r = '0; sh_c = sh_val[DATA_W-1];
          end else begin
            sh_r = '0; sh_c = 1'b0;
          end
        end
        SH_ASR: begin
          if (sh_amt[7:5] == '0) begin
            sh_r = asr_w[2*DATA_W-1:DATA_W]; sh_c = asr_w[DATA_W-1];
          end else begin
            sh_r = {DATA_W{sh_val[DATA_W-1]}}; sh_c = sh_val[DATA_W-1];
          end
        end
        SH_ROR: begin
          sh_r = ror_w[DATA_W-1:0]; sh_c = ror_w[DATA_W-1];
        end
        default: ;
      endcase
    end
  end

  // multiplier, low word kept
  assign mul_w = opnd_x * opnd_m;

  // flagless adder for pc/sp-relative and high-register adds
  assign imm_x4 = {22'd0, fa, 2'b00};
  always_comb begin
    pl_a   = opnd_x;
    pl_b   = imm_x4;
    pl_sub = 1'b0;
    case (op)
      OP_ADD_IMM_PC:  pl_a = opnd_x & PC_ALIGN_MASK;
      OP_SUB_DEC_SP:  pl_sub = 1'b1;
      OP_ADD_HIG_REG: pl_b = opnd_m;
      default: ;
    endcase
  end
  assign pl_sum = pl_sub ? (pl_a - pl_b) : (pl_a + pl_b);

  // result select and flag update
  always_comb begin
    r                = '0;
    nz               = 1'b1;
    res.dest_index   = fa[IDX_W-1:0];
    res.dest_written = 1'b1;
    res.flags        = flags_in;
    case (op)
      OP_ADD_REG, OP_SUB_REG, OP_ADD_IMM, OP_SUB_IMM, OP_ADC, OP_SBC, OP_NEG: begin
        r = add_sum[DATA_W-1:0];
        res.flags.c = add_sum[DATA_W]; res.flags.v = add_v;
      end
      OP_ADD_LAR_IMM, OP_SUB_LAR_IMM: begin
        r = add_sum[DATA_W-1:0]; res.dest_index = fb;
        res.flags.c = add_sum[DATA_W]; res.flags.v = add_v;
      end
      OP_CMP_IMM, OP_CMP_REG, OP_CMN, OP_CMP_HIG_REG: begin
        r = add_sum[DATA_W-1:0]; res.dest_written = 1'b0;
        res.flags.c = add_sum[DATA_W]; res.flags.v = add_v;
      end
      OP_MOV_IMM: begin
        r = {24'd0, fa}; res.dest_index = fb;
      end
      OP_LSL_IMM, OP_LSR_IMM, OP_ASR_IMM, OP_LSL_REG, OP_LSR_REG, OP_ASR_REG,
      OP_ROR: begin
        r = sh_r; res.flags.c = sh_c;
      end
      OP_AND: r = opnd_x & opnd_m;
      OP_EOR: r = opnd_x ^ opnd_m;
      OP_ORR: r = opnd_x | opnd_m;
      OP_BIC: r = opnd_x & ~opnd_m;
      OP_MVN: r = ~opnd_m;
      OP_MUL: r = mul_w[DATA_W-1:0];
      OP_TST: begin
        r = opnd_x & opnd_m; res.dest_written = 1'b0;
      end
      OP_ADD_IMM_PC, OP_ADD_IMM_SP: begin
        r = pl_sum; nz = 1'b0; res.dest_index = fb;
      end
      OP_ADD_INC_SP, OP_SUB_DEC_SP: begin
        r = pl_sum; nz = 1'b0; res.dest_index = SP_IDX;
      end
      OP_ADD_HIG_REG: begin
        r = pl_sum; nz = 1'b0;
      end
      OP_MOV_HIG_REG: begin
        r = opnd_m; nz = 1'b0;
      end
      // unknown codes change nothing
      default: begin
        r = '0; nz = 1'b0; res.dest_written = 1'b0;
      end
    endcase
    if (!res.dest_written) begin
      res.dest_index = '0;
    end
    if (nz) begin
      res.flags.n = r[DATA_W-1];
      res.flags.z = (r == '0);
    end
    res.result_value = r;
  end

endmodule

// ----- hw/rtl/thumb_data_processing_alu.sv -----
// Top level of the thumb data-processing execute block: stream ports, item and
// result registers, flag register. Uses thda_pkg, thda_regfile and thda_exec.
`timescale 1ns / 1ps

// Executes one decoded Thumb data-processing instruction per item against an
// internal 16 x 32-bit register file (r13 = SP, r15 = PC) and NZCV flags, both
// zero after reset. One item is taken every clock cycle while the output is not
// stalled. The accepting edge loads the item register and the register-file read;
// the result register is loaded after one execute pass once the output is free,
// and presents the result on the output. The register written by an
// item is forwarded to the read of the next item, so dependent instructions run
// back to back. A stalled result holds the output register; one more item may
// be taken and waits in the item register.
module thumb_data_processing_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation[5:0], field_a[13:6], field_b[17:14], field_c[22:18], zero[23]
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // result_value[31:0], dest_index[35:32], dest_written[36], flag_n[37],
  // flag_z[38], flag_c[39], flag_v[40], zero[47:41]
  output logic [47:0] out_tdata
);
  import thda_pkg::*;

  op_t               in_op;
  logic [FA_W-1:0]   in_fa;
  logic [FB_W-1:0]   in_fb;
  logic [FC_W-1:0]   in_fc;
  logic              in_acc;
  logic              exec_go;
  logic              item_vld_r;
  op_t               op_r;
  logic [FA_W-1:0]   fa_r;
  logic [FB_W-1:0]   fb_r;
  logic [FC_W-1:0]   fc_r;
  logic [DATA_W-1:0] opnd_m, opnd_x;
  flags_t            flags_r;
  exec_res_t         exec_res;
  rf_wr_t            rf_wr;
  logic              out_vld_r;
  exec_res_t         out_r;

  // input unpacking
  assign in_op = op_t'(in_tdata[5:0]);
  assign in_fa = in_tdata[13:6];
  assign in_fb = in_tdata[17:14];
  assign in_fc = in_tdata[22:18];

  // handshake
  assign exec_go   = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || exec_go;
  assign in_acc    = in_tvalid && in_tready;

  // item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_acc) begin
      item_vld_r <= 1'b1;
    end else if (exec_go) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= in_op;
      fa_r <= in_fa;
      fb_r <= in_fb;
      fc_r <= in_fc;
    end
  end

  // register file, read when the item is taken
  assign rf_wr.en   = exec_go && exec_res.dest_written;
  assign rf_wr.addr = exec_res.dest_index;
  assign rf_wr.data = exec_res.result_value;

  thda_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_acc),
    .rd_addr_a (in_fb),
    .rd_addr_b (opnd_sel(in_op, in_fa, in_fc)),
    .wr        (rf_wr),
    .rd_data_a (opnd_m),
    .rd_data_b (opnd_x)
  );

  // execute pass
  thda_exec u_exec (
    .op       (op_r),
    .fa       (fa_r),
    .fb       (fb_r),
    .fc       (fc_r),
    .opnd_m   (opnd_m),
    .opnd_x   (opnd_x),
    .flags_in (flags_r),
    .res      (exec_res)
  );

  // flag register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (exec_go) begin
      flags_r <= exec_res.flags;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (exec_go) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_r <= exec_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_r.flags.v, out_r.flags.c, out_r.flags.z, out_r.flags.n,
                       out_r.dest_written, out_r.dest_index, out_r.result_value};

  // an executed item always lands in the result register
  assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> out_tvalid)
    else $error("executed item did not reach the result register");

  // an item that cannot advance stays in the item register
  assert property (@(posedge clk) disable iff (!rst_n)
    item_vld_r && !exec_go |=> item_vld_r && $stable(op_r))
    else $error("stalled item lost");

  // a compare or test never writes the register file
  assert property (@(posedge clk) disable iff (!rst_n)
    rf_wr.en |-> exec_res.dest_written && item_vld_r)
    else $error("register write without a writing item");

endmodule
